/* design/cfld_pkg.sv */
// Shared types and constants for the cruise / follow / lane-change decider
package cfld_pkg;

    // Divider sizing: numerator is 2*|n| + d, divisor is 2*d
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 31;
    localparam int MAG_W     = NUM_W - 1;
    localparam int DSEL_W    = DEN_W - 1;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int ACC_W     = 46;

    // Configuration register indexes
    localparam logic [2:0] CFG_TARGET_SPEED = 3'd0;
    localparam logic [2:0] CFG_TARGET_GAP   = 3'd1;
    localparam logic [2:0] CFG_REACTION_MS  = 3'd2;
    localparam logic [2:0] CFG_PANIC_GAP    = 3'd3;
    localparam logic [2:0] CFG_MAX_ACCEL    = 3'd4;
    localparam logic [2:0] CFG_TICK_MS      = 3'd5;

    // Lane choice codes
    localparam logic [1:0] LANE_STAY  = 2'd0;
    localparam logic [1:0] LANE_LEFT  = 2'd1;
    localparam logic [1:0] LANE_RIGHT = 2'd2;

    // Which quotient the shared divider works on
    typedef enum logic [3:0] {
        DIV_SPEED   = 4'b0001,
        DIV_REL     = 4'b0010,
        DIV_BRAKE_V = 4'b0100,
        DIV_BRAKE_D = 4'b1000
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     prep;
        logic     prep2;
        logic     div_start;
        t_div_sel div_sel;
        logic     acc_add;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic ahead;
        logic dd_pos;
        logic vrel_neg;
        logic out_free;
    } t_status;

endpackage

/* design/cfld_div.sv */
// Restoring unsigned divider, one quotient bit per cycle
module cfld_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cfld_pkg::NUM_W-1:0]   i_num,
    input  logic [cfld_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [cfld_pkg::NUM_W-1:0]   o_quot
);

    logic [cfld_pkg::NUM_W-1:0]     r_q;
    logic [cfld_pkg::DEN_W-1:0]     r_rem;
    logic [cfld_pkg::DEN_W-1:0]     r_den;
    logic [cfld_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [cfld_pkg::DEN_W:0]       trial;
    logic                           fits;

    // trial subtract of the next numerator bit
    assign trial = {r_rem, r_q[cfld_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= cfld_pkg::DIV_CNT_W'(cfld_pkg::NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath of the divider
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[cfld_pkg::NUM_W-2:0], fits};
            if (fits) begin
                r_rem <= cfld_pkg::DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[cfld_pkg::DEN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* design/cfld_datapath.sv */
// Datapath: config registers, operand products, divider, accumulator, output word
module cfld_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfld_pkg::t_cmd        i_cmd,
    output cfld_pkg::t_status     o_status,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [14:0]           i_cfg_data,
    input  logic [4:0]            i_present_mask,
    input  logic signed [15:0]    i_ahead_gap,
    input  logic signed [15:0]    i_ahead_rel_speed,
    input  logic [14:0]           i_own_speed,
    input  logic signed [15:0]    i_lateral_offset,
    input  logic signed [15:0]    i_left_front_gap,
    input  logic signed [15:0]    i_left_front_rel_speed,
    input  logic signed [15:0]    i_left_back_gap,
    input  logic signed [15:0]    i_right_front_gap,
    input  logic signed [15:0]    i_right_front_rel_speed,
    input  logic signed [15:0]    i_right_back_gap,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic signed [15:0]    o_accel_cmd,
    output logic                  o_unsatisfied_flag,
    output logic [1:0]            o_lane_choice,
    output logic [15:0]           o_waited_ms
);

    // configuration
    logic [14:0] r_target_speed, r_target_gap, r_panic_gap;
    logic [13:0] r_reaction_ms, r_max_accel;
    logic [9:0]  r_tick_ms;
    logic [15:0] r_waited;

    // captured word
    logic [4:0]         r_mask;
    logic signed [15:0] r_gap, r_vrel, r_lat, r_lfg, r_lfv, r_lbg, r_rfg, r_rfv, r_rbg;
    logic [14:0]        r_own;

    // products
    logic signed [27:0] r_n_speed;
    logic signed [26:0] r_n_bv;
    logic signed [42:0] r_n_bd;
    logic [30:0]        r_wsq;
    logic [29:0]        r_dd16, r_tw, r_lf_k, r_lf_t, r_rf_k, r_rf_t;
    logic [27:0]        r_tt;
    logic [cfld_pkg::MAG_W-1:0]  r_wsq1000;
    logic [cfld_pkg::DSEL_W-1:0] r_den;
    logic               r_unsat;
    logic [1:0]         r_lane;
    logic signed [cfld_pkg::ACC_W-1:0] r_acc;
    logic               r_div_neg;

    // output word
    logic               r_out_valid;
    logic signed [15:0] r_accel;
    logic               r_flag;
    logic [1:0]         r_lane_out;

    logic [13:0]        t_eff;
    logic signed [16:0] sd;
    logic signed [17:0] dd;
    logic [15:0]        w;
    logic               dd_pos, dd_lt16, panic;
    logic signed [18:0] dd_pg;
    logic [cfld_pkg::DSEL_W-1:0] den_c;
    logic               left_ok, right_ok;
    logic [cfld_pkg::MAG_W-1:0]  mag;
    logic [cfld_pkg::DSEL_W-1:0] dsel;
    logic               neg;
    logic [27:0]        abs_speed;
    logic [26:0]        abs_bv;
    logic [42:0]        abs_bd;
    logic [cfld_pkg::NUM_W-1:0]  div_num;
    logic [cfld_pkg::DEN_W-1:0]  div_den;
    logic               div_done;
    logic [cfld_pkg::NUM_W-1:0]  div_quot;
    logic signed [cfld_pkg::ACC_W-1:0] qext, a_snap;
    logic               snap;
    logic [15:0]        base;
    logic [16:0]        wsum;
    logic [15:0]        lat_abs;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        abs16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    // one side is usable for a lane change
    function automatic logic side_ok(
        input logic fp, input logic bp,
        input logic signed [15:0] fg, input logic signed [15:0] fv,
        input logic signed [15:0] bg,
        input logic [29:0] fgk, input logic [29:0] tfv,
        input logic [14:0] pg, input logic [14:0] tg, input logic [14:0] ts);
        logic [15:0]        pg2;
        logic [16:0]        need;
        logic               never;
        logic               ok;
        logic signed [21:0] fv20;
        pg2   = {pg, 1'b0};
        need  = 17'(tg) + 17'(pg2);
        fv20  = 22'({{6{fv[15]}}, fv} * 22'd20);
        never = (fv == 16'sd0) || (!fg[15] && fg != 16'sd0 && fv[15])
              || (fg[15] && !fv[15] && fv != 16'sd0);
        ok = fp && bp;
        if (abs16(fg) < pg2 || abs16(bg) < pg2) ok = 1'b0;
        if ($signed({fg[15], fg[15], fg, 1'b0}) < $signed({2'b0, need})) ok = 1'b0;
        if (!never && (fg == 16'sd0 || !(fgk > tfv))) ok = 1'b0;
        if (!((fv20 + $signed({7'b0, ts})) > 22'sd0)) ok = 1'b0;
        side_ok = ok;
    endfunction

    // derived values of the captured word
    assign t_eff   = (r_reaction_ms == 14'd0) ? 14'd1 : r_reaction_ms;
    assign sd      = $signed({2'b0, r_own}) - $signed({2'b0, r_target_speed});
    assign dd      = $signed({{2{r_gap[15]}}, r_gap}) - $signed({3'b0, r_target_gap});
    assign w       = 16'(-r_vrel);
    assign dd_pos  = !dd[17] && (dd != 18'sd0);
    assign dd_lt16 = (dd[17:4] == 14'd0);
    assign dd_pg   = $signed({dd[17], dd}) + $signed({4'b0, r_panic_gap});
    assign panic   = dd_pg[18];
    assign den_c   = r_dd16 + 30'(w) * 30'd20;
    assign left_ok  = side_ok(r_mask[1], r_mask[2], r_lfg, r_lfv, r_lbg, r_lf_k, r_lf_t,
                              r_panic_gap, r_target_gap, r_target_speed);
    assign right_ok = side_ok(r_mask[3], r_mask[4], r_rfg, r_rfv, r_rbg, r_rf_k, r_rf_t,
                              r_panic_gap, r_target_gap, r_target_speed);

    // configuration writes and waited time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_speed <= 15'd7680;
            r_target_gap   <= 15'd480;
            r_reaction_ms  <= 14'd1000;
            r_panic_gap    <= 15'd160;
            r_max_accel    <= 14'd2560;
            r_tick_ms      <= 10'd20;
            r_waited       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    cfld_pkg::CFG_TARGET_SPEED: r_target_speed <= i_cfg_data;
                    cfld_pkg::CFG_TARGET_GAP:   r_target_gap   <= i_cfg_data;
                    cfld_pkg::CFG_REACTION_MS:  r_reaction_ms  <= i_cfg_data[13:0];
                    cfld_pkg::CFG_PANIC_GAP:    r_panic_gap    <= i_cfg_data;
                    cfld_pkg::CFG_MAX_ACCEL:    r_max_accel    <= i_cfg_data[13:0];
                    cfld_pkg::CFG_TICK_MS:      r_tick_ms      <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_waited <= r_unsat ? (wsum[16] ? 16'hFFFF : wsum[15:0]) : (base >> 1);
            end
        end
    end

    // capture, products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask <= i_present_mask;
            r_gap  <= i_ahead_gap;
            r_vrel <= i_ahead_rel_speed;
            r_own  <= i_own_speed;
            r_lat  <= i_lateral_offset;
            r_lfg  <= i_left_front_gap;
            r_lfv  <= i_left_front_rel_speed;
            r_lbg  <= i_left_back_gap;
            r_rfg  <= i_right_front_gap;
            r_rfv  <= i_right_front_rel_speed;
            r_rbg  <= i_right_back_gap;
        end
        if (i_cmd.prep) begin
            r_n_speed <= -({{11{sd[16]}}, sd} * 28'd1000);
            r_n_bv    <= 27'({{11{r_vrel[15]}}, r_vrel} * 27'd2000);
            r_n_bd    <= 43'({{25{dd[17]}}, dd} * 43'd16000000);
            r_wsq     <= 31'(w) * 31'(w);
            r_dd16    <= 30'({{12{dd[17]}}, dd} * 30'd16000);
            r_tw      <= 30'(t_eff) * 30'(w);
            r_tt      <= 28'(t_eff) * 28'(t_eff);
            r_lf_k    <= 30'(abs16(r_lfg)) * 30'd16000;
            r_lf_t    <= 30'(t_eff) * 30'(abs16(r_lfv));
            r_rf_k    <= 30'(abs16(r_rfg)) * 30'd16000;
            r_rf_t    <= 30'(t_eff) * 30'(abs16(r_rfv));
        end
        if (i_cmd.prep2) begin
            r_wsq1000 <= 41'(r_wsq) * 41'd1000;
            r_den     <= den_c;
            if (!r_mask[0]) begin
                r_unsat <= 1'b0;
            end else if (dd_pos) begin
                r_unsat <= dd_lt16 || (r_vrel[15] && (den_c < {r_tw, 1'b0}));
            end else begin
                r_unsat <= 1'b1;
            end
            if (r_mask[0] && !dd_pos && panic) begin
                r_acc <= -$signed({32'b0, r_max_accel});
            end else begin
                r_acc <= '0;
            end
            if ({14'b0, r_waited} > 30'(t_eff) && left_ok) begin
                r_lane <= cfld_pkg::LANE_LEFT;
            end else if ({14'b0, r_waited} > 30'(t_eff) && right_ok) begin
                r_lane <= cfld_pkg::LANE_RIGHT;
            end else begin
                r_lane <= cfld_pkg::LANE_STAY;
            end
        end
        if (i_cmd.div_start) begin
            r_div_neg <= neg;
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_div_neg ? r_acc - qext : r_acc + qext;
        end
    end

    // divider operands
    assign abs_speed = r_n_speed[27] ? 28'(-r_n_speed) : 28'(r_n_speed);
    assign abs_bv    = r_n_bv[26] ? 27'(-r_n_bv) : 27'(r_n_bv);
    assign abs_bd    = r_n_bd[42] ? 43'(-r_n_bd) : 43'(r_n_bd);

    always_comb begin
        unique case (i_cmd.div_sel)
            cfld_pkg::DIV_SPEED: begin
                mag  = cfld_pkg::MAG_W'(abs_speed);
                neg  = r_n_speed[27];
                dsel = cfld_pkg::DSEL_W'(t_eff);
            end
            cfld_pkg::DIV_REL: begin
                mag  = r_wsq1000;
                neg  = 1'b1;
                dsel = r_den;
            end
            cfld_pkg::DIV_BRAKE_V: begin
                mag  = cfld_pkg::MAG_W'(abs_bv);
                neg  = r_n_bv[26];
                dsel = cfld_pkg::DSEL_W'(t_eff);
            end
            cfld_pkg::DIV_BRAKE_D: begin
                mag  = abs_bd[cfld_pkg::MAG_W-1:0];
                neg  = r_n_bd[42];
                dsel = cfld_pkg::DSEL_W'(r_tt);
            end
            default: begin
                mag  = '0;
                neg  = 1'b0;
                dsel = cfld_pkg::DSEL_W'(t_eff);
            end
        endcase
    end

    // round to nearest: (2|n| + d) / 2d
    assign div_num = {mag, 1'b0} + cfld_pkg::NUM_W'(dsel);
    assign div_den = {dsel, 1'b0};

    cfld_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign qext = $signed({{(cfld_pkg::ACC_W - cfld_pkg::NUM_W){1'b0}}, div_quot});

    // lateral snap and waited-time update
    assign lat_abs = abs16(r_lat);
    assign snap    = lat_abs > 16'd128;
    always_comb begin
        a_snap = r_acc;
        if (snap && r_acc > 0) begin
            a_snap = r_acc + 46'sd256;
        end else if (snap && r_acc < 0) begin
            a_snap = r_acc - 46'sd256;
        end
    end
    assign base = (r_lane != cfld_pkg::LANE_STAY) ? 16'd0 : r_waited;
    assign wsum = {1'b0, base} + 17'(r_tick_ms);

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (a_snap > 46'sd32767) begin
                r_accel <= 16'sh7FFF;
            end else if (a_snap < -46'sd32768) begin
                r_accel <= -16'sh8000;
            end else begin
                r_accel <= a_snap[15:0];
            end
            r_flag     <= r_unsat;
            r_lane_out <= r_lane;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.ahead    = r_mask[0];
    assign o_status.dd_pos   = dd_pos;
    assign o_status.vrel_neg = r_vrel[15];
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_accel_cmd        = r_accel;
    assign o_unsatisfied_flag = r_flag;
    assign o_lane_choice      = r_lane_out;
    assign o_waited_ms        = r_waited;

endmodule

/* design/cfld_ctrl.sv */
// Controller: sequences capture, products, divisions and the result word
module cfld_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cfld_pkg::t_status  i_status,
    output cfld_pkg::t_cmd     o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_PREP2  = 6'b000100,
        ST_DSTART = 6'b001000,
        ST_DRUN   = 6'b010000,
        ST_FINAL  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    cfld_pkg::t_div_sel r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= cfld_pkg::DIV_SPEED;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_sel           = r_sel;
        o_cmd           = '0;
        o_cmd.div_sel   = r_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_PREP2;
            end
            ST_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_sel = (i_status.ahead && !i_status.dd_pos) ? cfld_pkg::DIV_BRAKE_V
                                                             : cfld_pkg::DIV_SPEED;
                n_state = ST_DSTART;
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DRUN;
            end
            ST_DRUN: begin
                if (i_status.div_done) begin
                    o_cmd.acc_add = 1'b1;
                    if (r_sel == cfld_pkg::DIV_SPEED && i_status.ahead
                        && i_status.dd_pos && i_status.vrel_neg) begin
                        n_sel   = cfld_pkg::DIV_REL;
                        n_state = ST_DSTART;
                    end else if (r_sel == cfld_pkg::DIV_BRAKE_V) begin
                        n_sel   = cfld_pkg::DIV_BRAKE_D;
                        n_state = ST_DSTART;
                    end else begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

/* design/cruise_follow_lane_decider.sv */
// Each word is captured, then its products are formed, then one division runs (no car
// ahead, or no closing term) or two divisions run, each with start, shifts and accumulate,
// on the shared divider; no new word is taken until the result step is done, and
// a stalled output holds the result step until it is free.
// A finished result waits in the output register while the next word is taken.
// Reset is synchronous, active low: restores config defaults, clears the waited time.
module cruise_follow_lane_decider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [4:0]         i_present_mask,
    input  logic signed [15:0] i_ahead_gap,
    input  logic signed [15:0] i_ahead_rel_speed,
    input  logic [14:0]        i_own_speed,
    input  logic signed [15:0] i_lateral_offset,
    input  logic signed [15:0] i_left_front_gap,
    input  logic signed [15:0] i_left_front_rel_speed,
    input  logic signed [15:0] i_left_back_gap,
    input  logic signed [15:0] i_right_front_gap,
    input  logic signed [15:0] i_right_front_rel_speed,
    input  logic signed [15:0] i_right_back_gap,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_accel_cmd,
    output logic               o_unsatisfied_flag,
    output logic [1:0]         o_lane_choice,
    output logic [15:0]        o_waited_ms
);

    cfld_pkg::t_cmd    cmd;
    cfld_pkg::t_status status;

    cfld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cfld_datapath u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .o_status                (status),
        .i_cfg_wr_en             (i_cfg_wr_en),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_present_mask          (i_present_mask),
        .i_ahead_gap             (i_ahead_gap),
        .i_ahead_rel_speed       (i_ahead_rel_speed),
        .i_own_speed             (i_own_speed),
        .i_lateral_offset        (i_lateral_offset),
        .i_left_front_gap        (i_left_front_gap),
        .i_left_front_rel_speed  (i_left_front_rel_speed),
        .i_left_back_gap         (i_left_back_gap),
        .i_right_front_gap       (i_right_front_gap),
        .i_right_front_rel_speed (i_right_front_rel_speed),
        .i_right_back_gap        (i_right_back_gap),
        .i_out_stall             (i_out_stall),
        .o_out_valid             (o_out_valid),
        .o_accel_cmd             (o_accel_cmd),
        .o_unsatisfied_flag      (o_unsatisfied_flag),
        .o_lane_choice           (o_lane_choice),
        .o_waited_ms             (o_waited_ms)
    );

endmodule

/* design/cfld_checker.sv */
// Port-level checks for the decider
module cfld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_unsatisfied_flag,
    input logic [1:0]  o_lane_choice,
    input logic [15:0] o_waited_ms
);

    // one word in flight: stall right after an accept
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // held result keeps its valid, waited time and lane choice
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_waited_ms)
                                          && $stable(o_lane_choice)))
        else $error("stalled result changed");

    // lane code legal
    a_lane_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lane_choice == cfld_pkg::LANE_STAY
                         || o_lane_choice == cfld_pkg::LANE_LEFT
                         || o_lane_choice == cfld_pkg::LANE_RIGHT))
        else $error("illegal lane code");

    // a lane change clears the waited time; halving zero stays zero
    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lane_choice != cfld_pkg::LANE_STAY && !o_unsatisfied_flag)
        |-> (o_waited_ms == 16'd0))
        else $error("waited time not cleared on lane change");

endmodule

bind cruise_follow_lane_decider cfld_checker u_cfld_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_unsatisfied_flag (o_unsatisfied_flag),
    .o_lane_choice      (o_lane_choice),
    .o_waited_ms        (o_waited_ms)
);
